// ===== design/frc_pkg.sv =====
// Package for the framed byte receiver: shared types, register map and reset values.
// Used by frc_cfg_regs, frc_core and frame_receiver_sum_check_timeout; no dependencies.
package frc_pkg;

	// Register map, index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_START_KEY     = 2'd0,
		REG_FRAME_LEN     = 2'd1,
		REG_TIMEOUT_TICKS = 2'd2,
		REG_NONE          = 2'd3
	} reg_idx_t;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [7:0]  START_KEY_RST = 8'h55;
	localparam logic [7:0]  FRAME_LEN_RST = 8'd71;
	localparam logic [15:0] TIMEOUT_RST   = 16'd2400;
	localparam logic [7:0]  MIN_LEN       = 8'd3;

	// Input item kinds
	typedef enum logic {
		FUNC_BYTE = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 24;

	typedef struct packed {
		logic [7:0]  start_key;
		logic [7:0]  frame_len;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       payload_valid;
		logic [6:0] payload_pos;
		logic [7:0] payload_byte;
		logic       frame_done;
		logic       high_match;
		logic       low_match;
		logic       link_lost;
		logic       timeout_alarm;
	} res_t;

endpackage

// ===== design/frc_cfg_regs.sv =====
// APB-style configuration registers for the framed byte receiver.
// Depends on frc_pkg for the register map and reset values.
module frc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [frc_pkg::ADDR_W-1:0]  paddr,
	input  logic [frc_pkg::DATA_W-1:0]  pwdata,
	output logic [frc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output frc_pkg::cfg_t               cfg
);
	import frc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register; addresses past the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_key     <= START_KEY_RST;
			cfg_q.frame_len     <= FRAME_LEN_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_START_KEY:     cfg_q.start_key     <= pwdata[7:0];
				REG_FRAME_LEN:     cfg_q.frame_len     <= pwdata[7:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		case (idx)
			REG_START_KEY:     prdata = {24'd0, cfg_q.start_key};
			REG_FRAME_LEN:     prdata = {24'd0, cfg_q.frame_len};
			REG_TIMEOUT_TICKS: prdata = {16'd0, cfg_q.timeout_ticks};
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== design/frc_core.sv =====
// Frame state and per-item result logic for the framed byte receiver.
// Depends on frc_pkg; the state advances when the top level moves an item to its result stage.
module frc_core #(
	parameter int unsigned MAX_FRAME_LEN = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  frc_pkg::cfg_t cfg,
	input  frc_pkg::item_t item,
	input  logic          adv,
	output frc_pkg::res_t res
);
	import frc_pkg::*;

	localparam logic [8:0] MaxLen = 9'(MAX_FRAME_LEN);

	logic        receiving_q;
	logic [7:0]  position_q;
	logic [15:0] sum_q;
	logic        high_ok_q;
	logic        low_ok_q;
	logic        pend_high_q;
	logic        frame_seen_q;
	logic [15:0] silence_q;
	logic        lost_q;

	logic        receiving_d;
	logic [7:0]  position_d;
	logic [15:0] sum_d;
	logic        high_ok_d;
	logic        low_ok_d;
	logic        pend_high_d;
	logic        frame_seen_d;
	logic [15:0] silence_d;
	logic        lost_d;

	logic [8:0]  len_lo;
	logic [8:0]  eff_len;
	logic [7:0]  high_pos;

	// Clamp the frame length to the supported range
	always_comb begin
		len_lo = (cfg.frame_len < MIN_LEN) ? {1'b0, MIN_LEN} : {1'b0, cfg.frame_len};
		eff_len = (len_lo > MaxLen) ? MaxLen : len_lo;
		high_pos = 8'(eff_len - 9'd2);
	end

	// Next state and result for the item at the input stage
	always_comb begin
		receiving_d  = receiving_q;
		position_d   = position_q;
		sum_d        = sum_q;
		high_ok_d    = high_ok_q;
		low_ok_d     = low_ok_q;
		pend_high_d  = pend_high_q;
		frame_seen_d = frame_seen_q;
		silence_d    = silence_q;
		lost_d       = lost_q;
		res          = '0;

		case (item.func)
			FUNC_BYTE: begin
				if (receiving_q) begin
					res.payload_valid = 1'b1;
					res.payload_pos   = position_q[6:0];
					res.payload_byte  = item.rx_byte;
					if (position_q < high_pos) begin
						sum_d = sum_q + {8'd0, item.rx_byte};
					end else if (position_q == high_pos) begin
						pend_high_d = (item.rx_byte == sum_q[15:8]);
					end else begin
						high_ok_d       = pend_high_q;
						low_ok_d        = (item.rx_byte == sum_q[7:0]);
						res.frame_done  = 1'b1;
						receiving_d     = 1'b0;
						frame_seen_d    = 1'b1;
					end
					position_d = position_q + 8'd1;
				end else if (item.rx_byte == cfg.start_key) begin
					receiving_d = 1'b1;
					position_d  = '0;
					sum_d       = '0;
					pend_high_d = 1'b0;
				end
			end
			FUNC_TICK: begin
				if (!frame_seen_q) begin
					// Count silence, saturating at full scale
					silence_d = (silence_q != 16'hFFFF) ? silence_q + 16'd1 : silence_q;
					if (silence_d >= cfg.timeout_ticks) begin
						lost_d            = 1'b1;
						res.timeout_alarm = 1'b1;
					end
				end else begin
					silence_d    = '0;
					frame_seen_d = 1'b0;
					lost_d       = 1'b0;
				end
			end
			default: begin
			end
		endcase

		res.high_match = high_ok_d;
		res.low_match  = low_ok_d;
		res.link_lost  = lost_d;
	end

	// Commit state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q  <= 1'b0;
			position_q   <= '0;
			sum_q        <= '0;
			high_ok_q    <= 1'b0;
			low_ok_q     <= 1'b0;
			pend_high_q  <= 1'b0;
			frame_seen_q <= 1'b0;
			silence_q    <= '0;
			lost_q       <= 1'b0;
		end else if (adv) begin
			receiving_q  <= receiving_d;
			position_q   <= position_d;
			sum_q        <= sum_d;
			high_ok_q    <= high_ok_d;
			low_ok_q     <= low_ok_d;
			pend_high_q  <= pend_high_d;
			frame_seen_q <= frame_seen_d;
			silence_q    <= silence_d;
			lost_q       <= lost_d;
		end
	end

endmodule

// ===== design/frame_receiver_sum_check_timeout.sv =====
// Framed byte receiver with 16-bit additive checksum and link-silence timeout.
// The block takes one item per clock cycle (a received byte or a timer tick) while the
// output is not stalled, and gives one result item for each: the item lands in an
// input register, the frame state and checksum compare run in one pass of short logic,
// and the result is held in an output register. While the output is stalled the input
// register takes one more item, and then the input stalls until the output moves on.
// Frame state (position, running sum, match flags, silence count) updates as an item
// moves into the output register. Registers: start_key at 0x0, frame_len at 0x4,
// timeout_ticks at 0x8; write them only while no item is in flight.
module frame_receiver_sum_check_timeout #(
	parameter int unsigned MAX_FRAME_LEN = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [frc_pkg::ADDR_W-1:0]      paddr,
	input  logic [frc_pkg::DATA_W-1:0]      pwdata,
	output logic [frc_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	// Input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [frc_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] rx_byte
	input  logic                            s_tuser,  // [0] func
	// Result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [frc_pkg::OUT_DATA_W-1:0]  m_tdata,  // [6:0] payload_pos, [14:7] payload_byte,
	                                                  // [15] high_match, [16] low_match,
	                                                  // [17] link_lost, [18] timeout_alarm,
	                                                  // [23:19] zero
	output logic                            m_tlast,  // frame_done
	output logic                            m_tuser   // [0] payload_valid
);
	import frc_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  adv_s2;
	logic  adv_s1;

	frc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage handshakes
	assign adv_s2   = valid_s1 & (~valid_s2 | m_tready);
	assign adv_s1   = s_tvalid & s_tready;
	assign s_tready = ~valid_s1 | adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			item_s1.func    <= func_t'(s_tuser);
			item_s1.rx_byte <= s_tdata[7:0];
		end
	end

	frc_core #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.adv    (adv_s2),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res;
		end
	end

	// Pack the result item
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.payload_valid;
	assign m_tlast  = res_s2.frame_done;
	assign m_tdata  = {5'd0, res_s2.timeout_alarm, res_s2.link_lost, res_s2.low_match,
		res_s2.high_match, res_s2.payload_byte, res_s2.payload_pos};

endmodule

// ===== test/tb_top.sv =====
// Testbench for frame_receiver_sum_check_timeout: sends received bytes and timer ticks
// on the input stream, predicts every result item in place and checks it field by field.
// Depends on frc_pkg and the design sources only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import frc_pkg::*;

	localparam int unsigned FRAME_MAX      = 128;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 200;

	logic                  clk;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [ADDR_W-1:0]     paddr   = '0;
	logic [DATA_W-1:0]     pwdata  = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;  // [7:0] rx_byte
	logic                  s_tuser  = 1'b0; // [0] func
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [6:0] pos, [14:7] byte, [15] high, [16] low,
	                                       // [17] lost, [18] alarm, [23:19] zero
	logic                  m_tlast;        // frame_done
	logic                  m_tuser;        // [0] payload_valid

	// Shadow of the configuration registers
	logic [7:0]  key_sh = START_KEY_RST;
	logic [7:0]  len_sh = FRAME_LEN_RST;
	logic [15:0] tmo_sh = TIMEOUT_RST;

	// Predicted receiver state
	bit          rcv_busy    = 1'b0;
	logic [7:0]  rcv_pos     = '0;
	logic [15:0] rcv_sum     = '0;
	bit          hi_pending  = 1'b0;
	bit          hi_ok       = 1'b0;
	bit          lo_ok       = 1'b0;
	bit          frame_flag  = 1'b0;
	logic [15:0] quiet_ticks = '0;
	bit          link_down   = 1'b0;

	res_t        pending_results[$];
	int unsigned counted_items  = 0;
	int unsigned results_seen   = 0;
	int unsigned mismatch_count = 0;

	// Idling controls
	bit          tx_gaps_on   = 1'b1;
	bit          rx_stalls_on = 1'b1;
	int unsigned rx_hold_left = 0;

	frame_receiver_sum_check_timeout #(
		.MAX_FRAME_LEN(FRAME_MAX)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Frame length as the receiver uses it: clamp into 3..FRAME_MAX
	function automatic int unsigned eff_frame_len();
		if (len_sh < MIN_LEN) return 32'(MIN_LEN);
		if (len_sh > FRAME_MAX) return FRAME_MAX;
		return 32'(len_sh);
	endfunction

	// Advance the predicted state by one item and return the result it causes
	function automatic res_t frame_predict(func_t f, logic [7:0] b);
		res_t        r;
		int unsigned n;
		r = '0;
		n = eff_frame_len();
		if (f == FUNC_BYTE) begin
			if (rcv_busy) begin
				r.payload_valid = 1'b1;
				r.payload_pos   = rcv_pos[6:0];
				r.payload_byte  = b;
				if (rcv_pos < n - 2) begin
					rcv_sum = rcv_sum + 16'(b);
				end else if (rcv_pos == n - 2) begin
					hi_pending = (b == rcv_sum[15:8]);
				end else begin
					hi_ok        = hi_pending;
					lo_ok        = (b == rcv_sum[7:0]);
					r.frame_done = 1'b1;
					rcv_busy     = 1'b0;
					frame_flag   = 1'b1;
				end
				rcv_pos = rcv_pos + 8'd1;
			end else if (b == key_sh) begin
				rcv_busy   = 1'b1;
				rcv_pos    = '0;
				rcv_sum    = '0;
				hi_pending = 1'b0;
			end
		end else begin
			// Count silence, or clear it if a frame completed since the last tick
			if (!frame_flag) begin
				if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
				if (quiet_ticks >= tmo_sh) begin
					link_down       = 1'b1;
					r.timeout_alarm = 1'b1;
				end
			end else begin
				quiet_ticks = '0;
				frame_flag  = 1'b0;
				link_down   = 1'b0;
			end
		end
		r.high_match = hi_ok;
		r.low_match  = lo_ok;
		r.link_lost  = link_down;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatch_count < 40) begin
			$display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
				$time, results_seen, what, got, want);
		end
		mismatch_count++;
	endtask

	// Compare one result item with the oldest prediction
	task automatic check_result();
		res_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result item with nothing pending", m_tdata, 0);
			return;
		end
		want = pending_results.pop_front();
		results_seen++;
		if (m_tuser !== want.payload_valid)
			report_mismatch("payload_valid", m_tuser, want.payload_valid);
		if (m_tdata[6:0] !== want.payload_pos)
			report_mismatch("payload_pos", m_tdata[6:0], want.payload_pos);
		if (m_tdata[14:7] !== want.payload_byte)
			report_mismatch("payload_byte", m_tdata[14:7], want.payload_byte);
		if (m_tlast !== want.frame_done)
			report_mismatch("frame_done", m_tlast, want.frame_done);
		if (m_tdata[15] !== want.high_match)
			report_mismatch("high_match", m_tdata[15], want.high_match);
		if (m_tdata[16] !== want.low_match)
			report_mismatch("low_match", m_tdata[16], want.low_match);
		if (m_tdata[17] !== want.link_lost)
			report_mismatch("link_lost", m_tdata[17], want.link_lost);
		if (m_tdata[18] !== want.timeout_alarm)
			report_mismatch("timeout_alarm", m_tdata[18], want.timeout_alarm);
		if (m_tdata[OUT_DATA_W-1:19] !== '0)
			report_mismatch("tdata padding", m_tdata[OUT_DATA_W-1:19], 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result();
	end

	// Receiver: long hold-off on request, otherwise random stall bursts
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no item moves on either side for too long
	initial begin
		int unsigned stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Offer one item, hold it until accepted, then record its prediction
	task automatic send_item(func_t f, logic [7:0] b);
		if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		counted_items++;
		pending_results.push_back(frame_predict(f, b));
		@(negedge clk);
	endtask

	// Drop valid and wait for every predicted result to come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_START_KEY:     key_sh = val[7:0];
			REG_FRAME_LEN:     len_sh = val[7:0];
			REG_TIMEOUT_TICKS: tmo_sh = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(logic [7:0] key, logic [7:0] len, logic [15:0] tmo);
		wait_drained();
		// let the last item clear the pipeline before touching registers
		repeat (4) @(negedge clk);
		cfg_write(REG_START_KEY, {24'd0, key});
		cfg_write(REG_FRAME_LEN, {24'd0, len});
		cfg_write(REG_TIMEOUT_TICKS, {16'd0, tmo});
	endtask

	// Payload byte with extra weight on the extremes and the start key
	function automatic logic [7:0] pick_byte();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) return 8'h00;
		if (sel == 1) return 8'hFF;
		if (sel == 2) return key_sh;
		return 8'($urandom);
	endfunction

	// Send a complete frame with its checksum, optionally corrupted
	task automatic send_frame(bit bad_hi, bit bad_lo, bit with_ticks);
		logic [15:0] sum;
		logic [7:0]  b;
		int unsigned n;
		// finish any frame left open by noise first
		while (rcv_busy) send_item(FUNC_BYTE, pick_byte());
		n   = eff_frame_len();
		sum = '0;
		send_item(FUNC_BYTE, key_sh);
		for (int unsigned i = 0; i < n - 2; i++) begin
			if (with_ticks && $urandom_range(0, 9) == 0) send_item(FUNC_TICK, 8'($urandom));
			b   = pick_byte();
			sum = sum + 16'(b);
			send_item(FUNC_BYTE, b);
		end
		send_item(FUNC_BYTE, sum[15:8] ^ (bad_hi ? 8'($urandom_range(1, 255)) : 8'h00));
		send_item(FUNC_BYTE, sum[7:0] ^ (bad_lo ? 8'($urandom_range(1, 255)) : 8'h00));
	endtask

	// Mostly well-formed frames, with tick bursts, noise and cut-off frames between
	task automatic run_random_items(int unsigned count);
		int unsigned stop_at;
		int unsigned sel;
		int unsigned burst;
		stop_at = counted_items + count;
		while (counted_items < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				send_frame($urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
					$urandom_range(0, 2) == 0);
			end else if (sel < 82) begin
				burst = $urandom_range(1, (tmo_sh < 38) ? tmo_sh + 2 : 40);
				repeat (burst) send_item(FUNC_TICK, 8'($urandom));
			end else if (sel < 92) begin
				repeat ($urandom_range(1, 6)) send_item(FUNC_BYTE, pick_byte());
			end else begin
				send_item(FUNC_BYTE, key_sh);
				repeat ($urandom_range(0, eff_frame_len() - 1))
					send_item(FUNC_BYTE, pick_byte());
			end
		end
	endtask

	// Reset settings: bytes other than the key are ignored, ticks count silence
	task automatic test_idle_bytes();
		send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_TICK, 8'hFF);
		send_item(FUNC_BYTE, 8'h54);
		send_item(FUNC_TICK, 8'h00);
	endtask

	// Shortest frame (length clamped up), zero timeout, key inside a frame,
	// tick mid-frame, stray bytes after a frame and both checksum failures
	task automatic test_short_frame();
		apply_setting(8'hFF, 8'd0, 16'd0);
		cfg_write(REG_NONE, 32'hFFFF_FFFF);
		send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_TICK, 8'hFF);
		send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_BYTE, 8'h80);
		send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_TICK, 8'h00);
		// both checksum bytes wrong
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_BYTE, 8'h01);
		send_item(FUNC_BYTE, 8'h01);
		send_item(FUNC_BYTE, 8'h00);
		// only the high byte wrong
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_BYTE, 8'h02);
		send_item(FUNC_BYTE, 8'h01);
		send_item(FUNC_BYTE, 8'h02);
		send_item(FUNC_TICK, 8'h00);
	endtask

	// Run silence up to and past the timeout, then recover with a frame
	task automatic test_long_silence();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		apply_setting(8'h55, 8'd3, 16'd100);
		repeat (120) send_item(FUNC_TICK, 8'($urandom));
		send_frame(1'b0, 1'b0, 1'b0);
		send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_TICK, 8'h00);
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// Hold the receiver off so the input stalls, then pause the sender until empty
	task automatic test_back_pressure();
		apply_setting(8'h00, 8'd3, 16'd1);
		rx_hold_left = HOLD_CYCLES;
		run_random_items(150);
		wait_drained();
		repeat (3) @(negedge clk);
		run_random_items(100);
	endtask

	task automatic test_random_settings();
		apply_setting(8'h55, 8'd71, 16'd2400);
		run_random_items(250);
		apply_setting(8'hFF, 8'd128, 16'hFFFF);
		run_random_items(200);
		apply_setting(8'hA5, 8'd255, 16'd5);
		run_random_items(200);
		apply_setting(8'h3C, 8'd1, 16'd0);
		run_random_items(150);
		repeat (2) begin
			apply_setting(8'($urandom), 8'($urandom_range(3, 24)), 16'($urandom_range(1, 40)));
			run_random_items(150);
		end
	endtask

	// Back-to-back items with no idling on either side
	task automatic test_steady_stream();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		apply_setting(8'($urandom), 8'($urandom_range(3, 12)), 16'($urandom_range(2, 12)));
		run_random_items(250);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_bytes();
		test_short_frame();
		test_long_silence();
		test_back_pressure();
		test_random_settings();
		test_steady_stream();

		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
